FILE: rtl/core/u2a_pkg.sv
// ============================================================================
// u2a_pkg
// Shared types, byte codes and the two-byte letter table for the UTF-8
// diacritic to ASCII converter.
// ============================================================================
package u2a_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_C3   = 2'd1,
        LEAD_C4   = 2'd2,
        LEAD_C5   = 2'd3
    } lead_t;

    localparam byte_t BYTE_NUL   = 8'h00;
    localparam byte_t BYTE_TAB   = 8'h09;
    localparam byte_t BYTE_LF    = 8'h0A;
    localparam byte_t BYTE_CR    = 8'h0D;
    localparam byte_t BYTE_SPACE = 8'h20;
    localparam byte_t BYTE_TILDE = 8'h7E;
    localparam byte_t BYTE_C3    = 8'hC3;
    localparam byte_t BYTE_C4    = 8'hC4;
    localparam byte_t BYTE_C5    = 8'hC5;

    localparam byte_t CAPACITY_RESET = 8'hFF;

    localparam int unsigned PADDR_W = 1;
    localparam logic [PADDR_W-1:0] ADDR_OUT_CAPACITY = 1'b0;

    // result of one processed request
    typedef struct packed {
        logic  emit;
        byte_t out_char;
        logic  end_of_text;
        lead_t lead_next;
        byte_t count_next;
    } step_t;

    // plain letter for a lead and a second byte, zero when unmapped
    function automatic byte_t map_pair(lead_t lead, byte_t second);
        byte_t ch;
        ch = BYTE_NUL;
        case (lead)
            LEAD_C3:
            begin
                case (second)
                    8'h93:   ch = "O";
                    8'hB3:   ch = "o";
                    default: ch = BYTE_NUL;
                endcase
            end
            LEAD_C4:
            begin
                case (second)
                    8'h84:   ch = "A";
                    8'h85:   ch = "a";
                    8'h86:   ch = "C";
                    8'h87:   ch = "c";
                    8'h98:   ch = "E";
                    8'h99:   ch = "e";
                    default: ch = BYTE_NUL;
                endcase
            end
            LEAD_C5:
            begin
                case (second)
                    8'h81:   ch = "L";
                    8'h82:   ch = "l";
                    8'h83:   ch = "N";
                    8'h84:   ch = "n";
                    8'h9A:   ch = "S";
                    8'h9B:   ch = "s";
                    8'hB9:   ch = "Z";
                    8'hBA:   ch = "z";
                    8'hBB:   ch = "Z";
                    8'hBC:   ch = "z";
                    default: ch = BYTE_NUL;
                endcase
            end
            default: ch = BYTE_NUL;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/u2a_apb.sv
// ============================================================================
// u2a_apb
// Configuration register file: holds the output capacity.
// ============================================================================
module u2a_apb
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u2a_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output u2a_pkg::byte_t                capacity
);

    u2a_pkg::byte_t capacity_reg;
    u2a_pkg::byte_t capacity_next;
    logic           wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == u2a_pkg::ADDR_OUT_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_hit)
        begin
            capacity_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= u2a_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == u2a_pkg::ADDR_OUT_CAPACITY)
        begin
            prdata = {24'd0, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

FILE: rtl/core/u2a_step.sv
// ============================================================================
// u2a_step
// Per-byte decode: classifies one byte against the held lead and the
// character count, and gives the result and the next state.
// ============================================================================
module u2a_step
(
    input  u2a_pkg::byte_t  in_byte,
    input  u2a_pkg::lead_t  lead,
    input  u2a_pkg::byte_t  count,
    input  u2a_pkg::byte_t  capacity,
    output u2a_pkg::step_t  step
);

    logic           room;
    u2a_pkg::byte_t ch;

    assign room = count < capacity;

    always_comb
    begin
        ch               = u2a_pkg::BYTE_NUL;
        step.emit        = 1'b0;
        step.out_char    = u2a_pkg::BYTE_NUL;
        step.end_of_text = 1'b0;
        step.lead_next   = lead;
        step.count_next  = count;

        if (in_byte == u2a_pkg::BYTE_NUL)
        begin
            step.emit        = 1'b1;
            step.end_of_text = 1'b1;
            step.lead_next   = u2a_pkg::LEAD_NONE;
            step.count_next  = 8'd0;
        end
        else
        begin
            if (lead != u2a_pkg::LEAD_NONE)
            begin
                ch             = u2a_pkg::map_pair(lead, in_byte);
                step.lead_next = u2a_pkg::LEAD_NONE;
            end
            else if (!room)
            begin
                ch = u2a_pkg::BYTE_NUL;
            end
            else if (in_byte >= u2a_pkg::BYTE_SPACE && in_byte <= u2a_pkg::BYTE_TILDE)
            begin
                ch = in_byte;
            end
            else if (in_byte == u2a_pkg::BYTE_C3)
            begin
                step.lead_next = u2a_pkg::LEAD_C3;
            end
            else if (in_byte == u2a_pkg::BYTE_C4)
            begin
                step.lead_next = u2a_pkg::LEAD_C4;
            end
            else if (in_byte == u2a_pkg::BYTE_C5)
            begin
                step.lead_next = u2a_pkg::LEAD_C5;
            end
            else if (in_byte == u2a_pkg::BYTE_TAB || in_byte == u2a_pkg::BYTE_LF
                     || in_byte == u2a_pkg::BYTE_CR)
            begin
                ch = u2a_pkg::BYTE_SPACE;
            end

            if (ch != u2a_pkg::BYTE_NUL && room)
            begin
                step.emit       = 1'b1;
                step.out_char   = ch;
                step.count_next = count + 8'd1;
            end
        end
    end

endmodule

FILE: rtl/core/utf8_diacritic_to_ascii.sv
// ============================================================================
// utf8_diacritic_to_ascii
// UTF-8 text to plain ASCII converter with Polish letter transliteration.
// ============================================================================
// One byte per request, one request per cycle sustained while the result side
// does not stall. A request is taken into an input register. In the following
// cycle it is decoded by a small letter table and the lead-byte state. Its
// result (if any) is written to the output register when the request advances
// out of the input register, which waits while a held result is stalled. A
// stalled result holds the input register, which then stalls the input.
// Printable ASCII passes, tab/CR/LF become a space, C3/C4/C5 lead pairs map to
// plain letters, and a zero byte always emits a terminator with end_of_text
// set. out_capacity (address 0, reset 255) caps the characters per string.
module utf8_diacritic_to_ascii
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u2a_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_char,
    output logic                          end_of_text
);

    u2a_pkg::byte_t capacity;
    u2a_pkg::step_t step;

    logic           in_valid_reg;
    logic           in_valid_next;
    u2a_pkg::byte_t byte_reg;
    u2a_pkg::lead_t lead_reg;
    u2a_pkg::lead_t lead_next;
    u2a_pkg::byte_t count_reg;
    u2a_pkg::byte_t count_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    u2a_pkg::byte_t out_char_reg;
    logic           eot_reg;

    logic           advance;
    logic           take;

    u2a_apb u_apb
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    u2a_step u_step
    (
        .in_byte  (byte_reg),
        .lead     (lead_reg),
        .count    (count_reg),
        .capacity (capacity),
        .step     (step)
    );

    // held request moves on once the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        lead_next      = lead_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            in_valid_next  = 1'b0;
            lead_next      = step.lead_next;
            count_next     = step.count_next;
            out_valid_next = step.emit;
        end
        if (take)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            lead_reg      <= u2a_pkg::LEAD_NONE;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            lead_reg      <= lead_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
        if (advance && step.emit)
        begin
            out_char_reg <= step.out_char;
            eot_reg      <= step.end_of_text;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign end_of_text = eot_reg;

`ifndef SYNTHESIS
    // terminator carries a zero character, any other result a nonzero one
    a_eot_char : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (eot_reg == (out_char_reg == u2a_pkg::BYTE_NUL)))
        else $error("terminator flag and character disagree");

    // a processed zero byte clears lead and count
    a_term_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && byte_reg == u2a_pkg::BYTE_NUL)
        |=> (lead_reg == u2a_pkg::LEAD_NONE && count_reg == 8'd0 && out_valid_reg))
        else $error("terminator did not clear state");

    // count only moves by one on an emitted character, or to zero
    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg))
        |-> (count_reg == 8'd0 || count_reg == $past(count_reg) + 8'd1))
        else $error("character count jumped");
`endif

endmodule
